// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the top level of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while the active-low reset is asserted.
`define HMMF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Clocked check that also holds during reset.
`define HMMF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMMF_ASSERT(label, clk, rst_n, prop, msg)
`define HMMF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/hmmf_pkg.sv =====
// Types, constants and arithmetic helpers of the HMM forward probability block.
package hmmf_pkg;

    localparam int MAX_STATES     = 8;
    localparam int MAX_SYMBOLS    = 16;
    localparam int PROB_FRAC_BITS = 31;
    localparam int PROB_W         = 32;
    localparam int STATE_W        = 3;
    localparam int SYM_W          = 4;
    localparam int NST_W          = 4;
    localparam int NSYM_W         = 5;
    localparam int CFG_W          = 5;
    localparam int TRANS_DEPTH    = MAX_STATES * MAX_STATES;
    localparam int EMIS_DEPTH     = MAX_STATES * MAX_SYMBOLS;

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(64'd1 << PROB_FRAC_BITS);

    // Configuration register indexes
    localparam logic CFG_NUM_STATES  = 1'b0;
    localparam logic CFG_NUM_SYMBOLS = 1'b1;

    localparam logic [NST_W-1:0]  NUM_STATES_RST  = 4'd5;
    localparam logic [NSYM_W-1:0] NUM_SYMBOLS_RST = 5'd10;

    typedef enum logic [1:0] {
        FUNC_LOAD_INIT  = 2'd0,
        FUNC_LOAD_TRANS = 2'd1,
        FUNC_LOAD_EMIS  = 2'd2,
        FUNC_OBSERVE    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_JSTART,
        S_TADDR,
        S_TMUL,
        S_TACC,
        S_EADDR,
        S_EMUL,
        S_EWR,
        S_FIN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic j_init;
        logic t_mul;
        logic t_acc;
        logic e_mul;
        logic e_wr;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic k_last;
        logic j_last;
        logic in_seq;
        logic is_last;
        logic out_full;
    } t_status;

    // Truncated fixed-point product; inputs never exceed one
    function automatic logic [PROB_W-1:0] prob_mul(input logic [PROB_W-1:0] a,
                                                   input logic [PROB_W-1:0] b);
        logic [2*PROB_W-1:0] p;
        p = (2*PROB_W)'(a) * (2*PROB_W)'(b);
        return p[PROB_FRAC_BITS +: PROB_W];
    endfunction

    // Sum saturating at one
    function automatic logic [PROB_W-1:0] sat_add(input logic [PROB_W-1:0] a,
                                                  input logic [PROB_W-1:0] b);
        logic [PROB_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, PROB_ONE}) ? PROB_ONE : s[PROB_W-1:0];
    endfunction

endpackage

// ===== rtl/core/hmmf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hmmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/hmmf_ctrl.sv =====
// Sequencer of the forward recursion: one multiply-accumulate step at a time.
module hmmf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_obs_accept,
    input  hmmf_pkg::t_status   i_status,
    output hmmf_pkg::t_cmd      o_cmd,
    output logic                o_busy
);
    import hmmf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_obs_accept) n_state = S_JSTART;
            S_JSTART: n_state = i_status.in_seq ? S_TADDR : S_EADDR;
            S_TADDR:  n_state = S_TMUL;
            S_TMUL:   n_state = S_TACC;
            S_TACC:   n_state = i_status.k_last ? S_EADDR : S_TADDR;
            S_EADDR:  n_state = S_EMUL;
            S_EMUL:   n_state = S_EWR;
            S_EWR:    n_state = i_status.j_last ? S_FIN : S_JSTART;
            S_FIN: begin
                if (!(i_status.is_last && i_status.out_full)) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.start = i_obs_accept;
            end
            S_JSTART: o_cmd.j_init = 1'b1;
            S_TMUL:   o_cmd.t_mul = 1'b1;
            S_TACC:   o_cmd.t_acc = 1'b1;
            S_EMUL:   o_cmd.e_mul = 1'b1;
            S_EWR:    o_cmd.e_wr = 1'b1;
            S_FIN:    o_cmd.finish = !(i_status.is_last && i_status.out_full);
            default:  o_cmd = '0;
        endcase
    end
endmodule

// ===== rtl/core/hmmf_dp.sv =====
// Datapath: probability stores, shared multiplier and saturating accumulator.
module hmmf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hmmf_pkg::t_cmd                 i_cmd,
    input  logic                           i_load,
    input  logic [1:0]                     i_func,
    input  logic [hmmf_pkg::STATE_W-1:0]   i_row_state,
    input  logic [hmmf_pkg::SYM_W-1:0]     i_col_index,
    input  logic [hmmf_pkg::PROB_W-1:0]    i_prob_value,
    input  logic [hmmf_pkg::SYM_W-1:0]     i_obs_symbol,
    input  logic                           i_last_obs,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [hmmf_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_out_stall,
    output hmmf_pkg::t_status              o_status,
    output logic                           o_out_valid,
    output logic [hmmf_pkg::PROB_W-1:0]    o_seq_prob,
    output logic                           o_out_status
);
    import hmmf_pkg::*;

    localparam int TA_W = $clog2(TRANS_DEPTH);
    localparam int EA_W = $clog2(EMIS_DEPTH);

    logic [NST_W-1:0]   r_num_states;
    logic [NSYM_W-1:0]  r_num_symbols;
    logic [PROB_W-1:0]  r_initial [MAX_STATES];
    logic [PROB_W-1:0]  r_alpha [MAX_STATES];
    logic [PROB_W-1:0]  r_next [MAX_STATES];
    logic [PROB_W-1:0]  r_acc;
    logic [PROB_W-1:0]  r_prod;
    logic [PROB_W-1:0]  r_sum;
    logic [STATE_W-1:0] r_j;
    logic [STATE_W-1:0] r_k;
    logic [NST_W-1:0]   r_n;
    logic [SYM_W-1:0]   r_sym;
    logic               r_sym_ok;
    logic               r_last;
    logic               r_in_seq;
    logic               r_err;
    logic               r_out_valid;
    logic [PROB_W-1:0]  r_out_prob;
    logic               r_out_status;

    logic [PROB_W-1:0]  load_val;
    logic [NST_W-1:0]   n_eff;
    logic [NSYM_W-1:0]  nsym_eff;
    logic               sym_ok;
    logic               trans_we;
    logic               emis_we;
    logic [PROB_W-1:0]  trans_rd;
    logic [PROB_W-1:0]  emis_rd;
    logic [PROB_W-1:0]  emis_use;

    // Load value clamp and effective counts
    assign load_val = (i_prob_value > PROB_ONE) ? PROB_ONE : i_prob_value;
    assign n_eff = (r_num_states == '0) ? NST_W'(1) :
                   (r_num_states > NST_W'(MAX_STATES)) ? NST_W'(MAX_STATES) : r_num_states;
    assign nsym_eff = (r_num_symbols == '0) ? NSYM_W'(1) :
                      (r_num_symbols > NSYM_W'(MAX_SYMBOLS)) ? NSYM_W'(MAX_SYMBOLS)
                                                             : r_num_symbols;
    assign sym_ok = {1'b0, i_obs_symbol} < nsym_eff;

    // Transition and emission stores
    assign trans_we = i_load && (i_func == FUNC_LOAD_TRANS) && !i_col_index[SYM_W-1];
    assign emis_we  = i_load && (i_func == FUNC_LOAD_EMIS);

    hmmf_ram #(.WIDTH(PROB_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (trans_we),
        .i_waddr (TA_W'({i_row_state, i_col_index[STATE_W-1:0]})),
        .i_wdata (load_val),
        .i_raddr (TA_W'({r_k, r_j})),
        .o_rdata (trans_rd)
    );

    hmmf_ram #(.WIDTH(PROB_W), .DEPTH(EMIS_DEPTH)) u_emis_ram (
        .i_clk   (i_clk),
        .i_we    (emis_we),
        .i_waddr (EA_W'({i_row_state, i_col_index})),
        .i_wdata (load_val),
        .i_raddr (EA_W'({r_j, r_sym})),
        .o_rdata (emis_rd)
    );

    assign emis_use = r_sym_ok ? emis_rd : '0;

    // Initial store
    always_ff @(posedge i_clk) begin
        if (i_load && (i_func == FUNC_LOAD_INIT)) begin
            r_initial[i_row_state] <= load_val;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states  <= NUM_STATES_RST;
            r_num_symbols <= NUM_SYMBOLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_STATES:  r_num_states  <= i_cfg_wdata[NST_W-1:0];
                CFG_NUM_SYMBOLS: r_num_symbols <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Payload of the recursion
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n      <= n_eff;
            r_sym    <= i_obs_symbol;
            r_sym_ok <= sym_ok;
            r_last   <= i_last_obs;
            r_j      <= '0;
            r_sum    <= '0;
            for (int i = 0; i < MAX_STATES; i++) r_next[i] <= '0;
        end
        if (i_cmd.j_init) begin
            r_acc <= r_in_seq ? '0 : r_initial[r_j];
            r_k   <= '0;
        end
        if (i_cmd.t_mul) r_prod <= prob_mul(r_alpha[r_k], trans_rd);
        if (i_cmd.t_acc) begin
            r_acc <= sat_add(r_acc, r_prod);
            r_k   <= r_k + STATE_W'(1);
        end
        if (i_cmd.e_mul) r_prod <= prob_mul(r_acc, emis_use);
        if (i_cmd.e_wr) begin
            r_next[r_j] <= r_prod;
            r_sum       <= sat_add(r_sum, r_prod);
            r_j         <= r_j + STATE_W'(1);
        end
        if (i_cmd.finish && r_last) begin
            r_out_prob   <= r_sum;
            r_out_status <= r_err;
        end
    end

    // Forward values and sequence flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_seq    <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_STATES; i++) r_alpha[i] <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (i_cmd.start && !sym_ok) r_err <= 1'b1;
            if (i_cmd.finish) begin
                for (int i = 0; i < MAX_STATES; i++) r_alpha[i] <= r_next[i];
                if (r_last) begin
                    r_out_valid <= 1'b1;
                    r_in_seq    <= 1'b0;
                    r_err       <= 1'b0;
                end else begin
                    r_in_seq <= 1'b1;
                end
            end
        end
    end

    assign o_status.k_last   = {1'b0, r_k} == (r_n - NST_W'(1));
    assign o_status.j_last   = {1'b0, r_j} == (r_n - NST_W'(1));
    assign o_status.in_seq   = r_in_seq;
    assign o_status.is_last  = r_last;
    assign o_status.out_full = r_out_valid;

    assign o_out_valid  = r_out_valid;
    assign o_seq_prob   = r_out_prob;
    assign o_out_status = r_out_status;
endmodule

// ===== rtl/core/hmm_forward_probability.sv =====
// Top level of the discrete HMM forward probability block.
//
// Input channel (i_valid / o_stall): one beat is a load or an observation.
// Loads (initial, transition, emission) go straight to the stores and
// give no result. An observation starts the forward recursion, which runs
// through one shared multiplier and a saturating accumulator.
// With n the clamped state count, an observation keeps o_stall high while
// the recursion runs: per state a setup step, then RAM read, multiply and
// accumulate for each of the n transition terms, RAM read, multiply and
// write for the emission, plus a finish step. The first observation of a
// sequence skips the transition terms.
// After the observation marked last, one result beat carries the sequence
// probability and the error flag on the output channel (o_valid / i_stall).
// The result sits in an output register: new beats are accepted while it
// waits; only a further last observation waits at its end until it is taken.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata
// while the block is idle, a rule for the user that the block does not
// enforce. Reset clears the sequence state, the forward values and the
// register defaults; the probability stores must be loaded.
module hmm_forward_probability (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_func,
    input  logic [hmmf_pkg::STATE_W-1:0]  i_row_state,
    input  logic [hmmf_pkg::SYM_W-1:0]    i_col_index,
    input  logic [hmmf_pkg::PROB_W-1:0]   i_prob_value,
    input  logic [hmmf_pkg::SYM_W-1:0]    i_obs_symbol,
    input  logic                          i_last_obs,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hmmf_pkg::PROB_W-1:0]   o_seq_prob,
    output logic                          o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [hmmf_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import hmmf_pkg::*;

    `include "assert_macros.svh"

    t_cmd    cmd;
    t_status status;
    logic    busy;
    logic    in_accept;
    logic    obs_accept;
    logic    load_accept;

    assign o_stall     = busy;
    assign in_accept   = i_valid && !busy;
    assign obs_accept  = in_accept && (i_func == FUNC_OBSERVE);
    assign load_accept = in_accept && (i_func != FUNC_OBSERVE);

    hmmf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_obs_accept (obs_accept),
        .i_status     (status),
        .o_cmd        (cmd),
        .o_busy       (busy)
    );

    hmmf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_load       (load_accept),
        .i_func       (i_func),
        .i_row_state  (i_row_state),
        .i_col_index  (i_col_index),
        .i_prob_value (i_prob_value),
        .i_obs_symbol (i_obs_symbol),
        .i_last_obs   (i_last_obs),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_stall),
        .o_status     (status),
        .o_out_valid  (o_valid),
        .o_seq_prob   (o_seq_prob),
        .o_out_status (o_status)
    );

    // Checks
    `HMMF_ASSERT(a_obs_busy, i_clk, i_rst_n, obs_accept |=> o_stall, "observation did not start")
    `HMMF_ASSERT(a_res_from_fin, i_clk, i_rst_n, $rose(o_valid) |-> $past(cmd.finish), "no finish")
    `HMMF_ASSERT_ALWAYS(a_cmd_onehot, i_clk, $onehot0(cmd), "overlapping commands")
endmodule
